// ===== design/sesm_pkg.sv =====
// ----------------------------------------------------------------------------
// sesm_pkg: shared types and constants for the sparse entry sort/merge core
// beat structs, store word layout, sequencer states and sizing constants
// ----------------------------------------------------------------------------
package sesm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int INDEX_WIDTH = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W  = 2 * INDEX_WIDTH;
  localparam int ACC_W  = VALUE_WIDTH + CNT_W;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]        entry_row;
    logic [INDEX_WIDTH-1:0]        entry_col;
    logic signed [VALUE_WIDTH-1:0] entry_re;
    logic signed [VALUE_WIDTH-1:0] entry_im;
    logic                          entry_last;
  } in_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]        out_row;
    logic [INDEX_WIDTH-1:0]        out_col;
    logic signed [VALUE_WIDTH-1:0] sum_re;
    logic signed [VALUE_WIDTH-1:0] sum_im;
    logic                          sum_saturated;
    logic                          entries_dropped;
    logic                          out_last;
  } out_t;

  // one word of the entry store
  typedef struct packed {
    logic [INDEX_WIDTH-1:0]        row;
    logic [INDEX_WIDTH-1:0]        col;
    logic signed [VALUE_WIDTH-1:0] re;
    logic signed [VALUE_WIDTH-1:0] im;
  } store_word_t;

  localparam int STORE_W = $bits(store_word_t);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ===== design/sesm_ram.sv =====
// ----------------------------------------------------------------------------
// sesm_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sesm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sparse_entry_sort_merge_core.sv =====
// ----------------------------------------------------------------------------
// sparse_entry_sort_merge_core: coo entry sorter with duplicate summation
// operation: load takes one entry per cycle; after the last entry each merged
//   result costs a full pass over the n stored entries and is then held in the
//   output register until it is taken
// throughput: one load beat per cycle; in_stall stays high from the last beat
//   until the final result beat is taken; the single memory read port sets this
// reset: state, entry count, overflow flag and read-valid flag clear; the store is not cleared
// ----------------------------------------------------------------------------
module sparse_entry_sort_merge_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sesm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sesm_pkg::out_t  out_data
);

  // sequencer and load bookkeeping
  sesm_pkg::state_t              state_r, state_nxt;
  logic [sesm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;     // entries held in the store
  logic                          ovf_r, ovf_nxt;     // an entry was dropped this load

  // scan pass: read address and read-data-valid pipeline flag
  logic [sesm_pkg::CNT_W-1:0]    ra_r, ra_nxt;
  logic                          rv_r, rv_nxt;

  // selection of the next key above the one last emitted
  logic                          first_r, first_nxt; // no lower bound yet
  logic                          found_r, found_nxt;
  logic [sesm_pkg::KEY_W-1:0]    prev_r, prev_nxt;
  logic [sesm_pkg::KEY_W-1:0]    cand_r, cand_nxt;
  logic signed [sesm_pkg::ACC_W-1:0] acc_re_r, acc_re_nxt;
  logic signed [sesm_pkg::ACC_W-1:0] acc_im_r, acc_im_nxt;
  logic [sesm_pkg::CNT_W-1:0]    grp_r, grp_nxt;     // duplicates in the group
  logic [sesm_pkg::CNT_W-1:0]    done_r, done_nxt;   // entries already emitted

  sesm_pkg::out_t                out_r, out_nxt;

  // memory port
  logic                          wr_en;
  logic [sesm_pkg::ADDR_W-1:0]   wr_addr;
  sesm_pkg::store_word_t         wr_word;
  logic                          rd_en;
  logic [sesm_pkg::STORE_W-1:0]  rd_raw;
  sesm_pkg::store_word_t         rd_word;

  // shared compare / add unit
  logic [sesm_pkg::KEY_W-1:0]    key;
  logic                          eligible;
  logic signed [sesm_pkg::ACC_W-1:0] ext_re, ext_im;
  logic signed [sesm_pkg::ACC_W-1:0] sum_re, sum_im;

  // saturation of the finished group
  logic                          clip_re, clip_im;
  logic signed [sesm_pkg::VALUE_WIDTH-1:0] sat_re, sat_im;

  logic                          in_beat;
  logic                          out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  assign in_stall  = (state_r != sesm_pkg::ST_LOAD);
  assign out_valid = (state_r == sesm_pkg::ST_EMIT);
  assign out_data  = out_r;

  // store write during load, only while there is room
  assign wr_en   = in_beat && (cnt_r < sesm_pkg::CNT_W'(sesm_pkg::MAX_ENTRIES));
  assign wr_addr = cnt_r[sesm_pkg::ADDR_W-1:0];
  assign wr_word = '{row: in_data.entry_row, col: in_data.entry_col,
                     re: in_data.entry_re, im: in_data.entry_im};

  assign rd_en   = (state_r == sesm_pkg::ST_SCAN) && (ra_r < cnt_r);
  assign rd_word = sesm_pkg::store_word_t'(rd_raw);

  sesm_ram #(
    .WIDTH (sesm_pkg::STORE_W),
    .DEPTH (sesm_pkg::MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (ra_r[sesm_pkg::ADDR_W-1:0]),
    .rd_data (rd_raw)
  );

  // one entry per cycle through the key compare and the accumulate adders
  assign key      = {rd_word.row, rd_word.col};
  assign eligible = first_r || (key > prev_r);
  assign ext_re   = {{(sesm_pkg::ACC_W-sesm_pkg::VALUE_WIDTH){rd_word.re[sesm_pkg::VALUE_WIDTH-1]}},
                     rd_word.re};
  assign ext_im   = {{(sesm_pkg::ACC_W-sesm_pkg::VALUE_WIDTH){rd_word.im[sesm_pkg::VALUE_WIDTH-1]}},
                     rd_word.im};
  assign sum_re   = acc_re_r + ext_re;
  assign sum_im   = acc_im_r + ext_im;

  // clipped when the bits above the value width disagree with its sign bit
  assign clip_re = (acc_re_r[sesm_pkg::ACC_W-1:sesm_pkg::VALUE_WIDTH-1] != '0) &&
                   (acc_re_r[sesm_pkg::ACC_W-1:sesm_pkg::VALUE_WIDTH-1] != '1);
  assign clip_im = (acc_im_r[sesm_pkg::ACC_W-1:sesm_pkg::VALUE_WIDTH-1] != '0) &&
                   (acc_im_r[sesm_pkg::ACC_W-1:sesm_pkg::VALUE_WIDTH-1] != '1);

  always_comb begin
    sat_re = acc_re_r[sesm_pkg::VALUE_WIDTH-1:0];
    sat_im = acc_im_r[sesm_pkg::VALUE_WIDTH-1:0];
    if (clip_re) begin
      sat_re = acc_re_r[sesm_pkg::ACC_W-1] ?
               {1'b1, {(sesm_pkg::VALUE_WIDTH-1){1'b0}}} :
               {1'b0, {(sesm_pkg::VALUE_WIDTH-1){1'b1}}};
    end
    if (clip_im) begin
      sat_im = acc_im_r[sesm_pkg::ACC_W-1] ?
               {1'b1, {(sesm_pkg::VALUE_WIDTH-1){1'b0}}} :
               {1'b0, {(sesm_pkg::VALUE_WIDTH-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    ra_nxt     = ra_r;
    rv_nxt     = 1'b0;
    first_nxt  = first_r;
    found_nxt  = found_r;
    prev_nxt   = prev_r;
    cand_nxt   = cand_r;
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    grp_nxt    = grp_r;
    done_nxt   = done_r;
    out_nxt    = out_r;

    case (state_r)
      sesm_pkg::ST_LOAD: begin
        if (in_beat) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.entry_last) begin
            // start the first selection pass with no lower bound
            state_nxt = sesm_pkg::ST_SCAN;
            ra_nxt    = '0;
            first_nxt = 1'b1;
            found_nxt = 1'b0;
            done_nxt  = '0;
          end
        end
      end

      sesm_pkg::ST_SCAN: begin
        if (rd_en) begin
          ra_nxt = ra_r + 1'b1;
          rv_nxt = 1'b1;
        end
        if (rv_r) begin
          if (eligible && (!found_r || (key < cand_r))) begin
            // smaller candidate: restart the group
            found_nxt  = 1'b1;
            cand_nxt   = key;
            acc_re_nxt = ext_re;
            acc_im_nxt = ext_im;
            grp_nxt    = sesm_pkg::CNT_W'(1);
          end else if (eligible && (key == cand_r)) begin
            acc_re_nxt = sum_re;
            acc_im_nxt = sum_im;
            grp_nxt    = grp_r + 1'b1;
          end
        end else if (!rd_en) begin
          // pass complete: the group is final
          state_nxt = sesm_pkg::ST_EMIT;
          out_nxt   = '{
            out_row:         cand_r[sesm_pkg::KEY_W-1:sesm_pkg::INDEX_WIDTH],
            out_col:         cand_r[sesm_pkg::INDEX_WIDTH-1:0],
            sum_re:          sat_re,
            sum_im:          sat_im,
            sum_saturated:   clip_re || clip_im,
            entries_dropped: ovf_r,
            out_last:        (done_r + grp_r) == cnt_r
          };
        end
      end

      sesm_pkg::ST_EMIT: begin
        if (out_beat) begin
          if (out_r.out_last) begin
            state_nxt = sesm_pkg::ST_LOAD;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            state_nxt = sesm_pkg::ST_SCAN;
            ra_nxt    = '0;
            first_nxt = 1'b0;
            found_nxt = 1'b0;
            prev_nxt  = cand_r;
            done_nxt  = done_r + grp_r;
          end
        end
      end

      default: begin
        state_nxt = sesm_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sesm_pkg::ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    ra_r     <= ra_nxt;
    first_r  <= first_nxt;
    found_r  <= found_nxt;
    prev_r   <= prev_nxt;
    cand_r   <= cand_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    grp_r    <= grp_nxt;
    done_r   <= done_nxt;
    out_r    <= out_nxt;
  end

endmodule

// ===== design/sesm_checker.sv =====
// ----------------------------------------------------------------------------
// sesm_checker: port-level checks for the sparse entry sort/merge core
// watches the handshake ports over time, bound to the top level
// ----------------------------------------------------------------------------
module sesm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input sesm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input sesm_pkg::out_t out_data
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no load beat is taken while a result is pending
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // an entry that does not end the load gives no result
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.entry_last |=> !out_valid && !in_stall)
    else $error("non-last entry caused a result or stall");

  // after the final result the load side opens again
  a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.out_last |=> !in_stall && !out_valid)
    else $error("load not reopened after final result");

  // more results follow a non-final beat, so the input stays closed
  a_closed_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.out_last |=> in_stall)
    else $error("input opened mid run");

endmodule

bind sparse_entry_sort_merge_core sesm_checker u_sesm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
